[rtl/segment_continuation_test_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the segment continuation test
// Shared concurrent assertion forms used at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef SEGMENT_CONTINUATION_TEST_MACROS_SVH
`define SEGMENT_CONTINUATION_TEST_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define SCT_ASSERT_IMPLIES(label, clk, rst, lhs, rhs, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define SCT_ASSERT_NEXT(label, clk, rst, lhs, rhs, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
      else $error(msg);

`endif

[rtl/sct_pkg.sv]
// ----------------------------------------------------------------------------
// Segment continuation test package
// Orientation and status codes, register constants and the control record
// that travels with each item from the front to the back.
// ----------------------------------------------------------------------------
package sct_pkg;

   // Orientation codes of one segment.
   localparam logic [1:0] ORI_VERT = 2'd0;
   localparam logic [1:0] ORI_HORZ = 2'd1;
   localparam logic [1:0] ORI_DIAG = 2'd2;

   // Result status codes.
   localparam logic [1:0] ST_DECIDED   = 2'd0;
   localparam logic [1:0] ST_ZERO_LEN  = 2'd1;
   localparam logic [1:0] ST_BOTH_DIAG = 2'd2;

   // Distance bound register.
   localparam int unsigned MAX_DIST_BITS = 12;
   localparam logic [MAX_DIST_BITS-1:0] MAX_DIST_RESET = 12'd8;

   // Classification result of one item.
   typedef struct packed {
      logic       check;
      logic [1:0] status;
      logic [1:0] a_ori;
      logic [1:0] b_ori;
   } ctrl_type;

endpackage

[rtl/sct_front.sv]
// ----------------------------------------------------------------------------
// Segment continuation test front end
// Classifies both segments and picks the facing endpoints along the main axis.
// ----------------------------------------------------------------------------
module sct_front #(
   parameter int unsigned COORD_BITS = 12
) (
   input  logic [COORD_BITS-1:0] a_start_x,
   input  logic [COORD_BITS-1:0] a_start_y,
   input  logic [COORD_BITS-1:0] a_end_x,
   input  logic [COORD_BITS-1:0] a_end_y,
   input  logic [COORD_BITS-1:0] b_start_x,
   input  logic [COORD_BITS-1:0] b_start_y,
   input  logic [COORD_BITS-1:0] b_end_x,
   input  logic [COORD_BITS-1:0] b_end_y,
   output sct_pkg::ctrl_type     ctrl,
   output logic [COORD_BITS-1:0] far_main,
   output logic [COORD_BITS-1:0] far_cross,
   output logic [COORD_BITS-1:0] near_main,
   output logic [COORD_BITS-1:0] near_cross
);

   localparam int unsigned MUL_BITS = COORD_BITS + 3;

   // Exact slope test: 5*dy against 4*dx and 6*dx.
   function automatic logic [1:0] classify(
      input logic [COORD_BITS-1:0] x0,
      input logic [COORD_BITS-1:0] y0,
      input logic [COORD_BITS-1:0] x1,
      input logic [COORD_BITS-1:0] y1
   );
      logic [COORD_BITS-1:0] dx;
      logic [COORD_BITS-1:0] dy;
      logic [MUL_BITS-1:0]   dy5;
      logic [MUL_BITS-1:0]   dx4;
      logic [MUL_BITS-1:0]   dx6;
      logic [1:0]            ori;
      dx  = (x0 > x1) ? (x0 - x1) : (x1 - x0);
      dy  = (y0 > y1) ? (y0 - y1) : (y1 - y0);
      dy5 = MUL_BITS'(dy) + (MUL_BITS'(dy) << 2);
      dx4 = MUL_BITS'(dx) << 2;
      dx6 = (MUL_BITS'(dx) << 2) + (MUL_BITS'(dx) << 1);
      if (dy == '0) begin
         ori = sct_pkg::ORI_HORZ;
      end else if (dx == '0) begin
         ori = sct_pkg::ORI_VERT;
      end else if (dy5 < dx4) begin
         ori = sct_pkg::ORI_HORZ;
      end else if (dy5 > dx6) begin
         ori = sct_pkg::ORI_VERT;
      end else begin
         ori = sct_pkg::ORI_DIAG;
      end
      return ori;
   endfunction

   logic                  a_zero;
   logic                  b_zero;
   logic [1:0]            a_ori;
   logic [1:0]            b_ori;
   logic                  vert;
   logic [COORD_BITS-1:0] as_main, as_cross, ae_main, ae_cross;
   logic [COORD_BITS-1:0] bs_main, bs_cross, be_main, be_cross;
   logic [COORD_BITS-1:0] fs_main, fs_cross, fe_main, fe_cross;
   logic [COORD_BITS-1:0] ss_main, ss_cross, se_main, se_cross;
   logic [COORD_BITS-1:0] a_min;
   logic [COORD_BITS-1:0] b_min;
   logic                  a_first;

   // Orientation of each segment; a zero-length segment reads as code zero.
   assign a_zero = (a_start_x == a_end_x) && (a_start_y == a_end_y);
   assign b_zero = (b_start_x == b_end_x) && (b_start_y == b_end_y);
   assign a_ori  = a_zero ? sct_pkg::ORI_VERT
                          : classify(a_start_x, a_start_y, a_end_x, a_end_y);
   assign b_ori  = b_zero ? sct_pkg::ORI_VERT
                          : classify(b_start_x, b_start_y, b_end_x, b_end_y);

   // Status and whether the endpoint test decides the result.
   always_comb begin
      ctrl.a_ori = a_ori;
      ctrl.b_ori = b_ori;
      ctrl.check = 1'b0;
      if (a_zero || b_zero) begin
         ctrl.status = sct_pkg::ST_ZERO_LEN;
      end else if (a_ori != b_ori) begin
         ctrl.status = sct_pkg::ST_DECIDED;
      end else if (a_ori == sct_pkg::ORI_DIAG) begin
         ctrl.status = sct_pkg::ST_BOTH_DIAG;
      end else begin
         ctrl.status = sct_pkg::ST_DECIDED;
         ctrl.check  = 1'b1;
      end
   end

   // Map coordinates onto the main and cross axes of the first segment's class.
   assign vert     = (a_ori == sct_pkg::ORI_VERT);
   assign as_main  = vert ? a_start_y : a_start_x;
   assign as_cross = vert ? a_start_x : a_start_y;
   assign ae_main  = vert ? a_end_y   : a_end_x;
   assign ae_cross = vert ? a_end_x   : a_end_y;
   assign bs_main  = vert ? b_start_y : b_start_x;
   assign bs_cross = vert ? b_start_x : b_start_y;
   assign be_main  = vert ? b_end_y   : b_end_x;
   assign be_cross = vert ? b_end_x   : b_end_y;

   // The earlier segment has the smaller leading coordinate; a tie favors b.
   assign a_min   = (as_main < ae_main) ? as_main : ae_main;
   assign b_min   = (bs_main < be_main) ? bs_main : be_main;
   assign a_first = (a_min < b_min);

   assign fs_main  = a_first ? as_main  : bs_main;
   assign fs_cross = a_first ? as_cross : bs_cross;
   assign fe_main  = a_first ? ae_main  : be_main;
   assign fe_cross = a_first ? ae_cross : be_cross;
   assign ss_main  = a_first ? bs_main  : as_main;
   assign ss_cross = a_first ? bs_cross : as_cross;
   assign se_main  = a_first ? be_main  : ae_main;
   assign se_cross = a_first ? be_cross : ae_cross;

   // Far end of the earlier segment and near end of the later one.
   always_comb begin
      if (fs_main < fe_main) begin
         far_main  = fe_main;
         far_cross = fe_cross;
      end else begin
         far_main  = fs_main;
         far_cross = fs_cross;
      end
      if (ss_main < se_main) begin
         near_main  = ss_main;
         near_cross = ss_cross;
      end else begin
         near_main  = se_main;
         near_cross = se_cross;
      end
   end

endmodule

[rtl/sct_queue.sv]
// ----------------------------------------------------------------------------
// Segment continuation test queue
// Short first-in first-out buffer between the front and the back.
// ----------------------------------------------------------------------------
module sct_queue #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic [WIDTH-1:0] head_data,
   output logic             full,
   output logic             empty
);

   localparam int unsigned PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_BITS = $clog2(DEPTH + 1);
   localparam logic [PTR_BITS-1:0] LAST_PTR = PTR_BITS'(DEPTH - 1);
   localparam logic [CNT_BITS-1:0] FULL_CNT = CNT_BITS'(DEPTH);

   logic [WIDTH-1:0]    entry_ff [DEPTH];
   logic [PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0] count_ff, count_in;

   assign full      = (count_ff == FULL_CNT);
   assign empty     = (count_ff == '0);
   assign head_data = entry_ff[rd_ptr_ff];

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage needs no reset.
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

[rtl/sct_back.sv]
// ----------------------------------------------------------------------------
// Segment continuation test back end
// Applies the endpoint distance test and holds the result in an output register.
// ----------------------------------------------------------------------------
module sct_back #(
   parameter int unsigned COORD_BITS = 12
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic [sct_pkg::MAX_DIST_BITS-1:0]  max_dist,
   input  logic                               q_empty,
   input  sct_pkg::ctrl_type                  q_ctrl,
   input  logic [COORD_BITS-1:0]              q_far_main,
   input  logic [COORD_BITS-1:0]              q_far_cross,
   input  logic [COORD_BITS-1:0]              q_near_main,
   input  logic [COORD_BITS-1:0]              q_near_cross,
   output logic                               q_pop,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic                               rsp_same_line,
   output logic [1:0]                         rsp_status,
   output logic [1:0]                         rsp_a_orientation,
   output logic [1:0]                         rsp_b_orientation
);

   localparam int unsigned CMP_BITS = (COORD_BITS > sct_pkg::MAX_DIST_BITS)
                                      ? COORD_BITS : sct_pkg::MAX_DIST_BITS;

   logic                  valid_ff, valid_in;
   logic                  same_ff;
   logic [1:0]            status_ff;
   logic [1:0]            a_ori_ff;
   logic [1:0]            b_ori_ff;
   logic [COORD_BITS-1:0] gap_main;
   logic [COORD_BITS-1:0] gap_cross;
   logic                  close;

   // Both the gap along the line and the offset across it must be short.
   assign gap_main  = (q_far_main > q_near_main) ? (q_far_main - q_near_main)
                                                 : (q_near_main - q_far_main);
   assign gap_cross = (q_far_cross > q_near_cross) ? (q_far_cross - q_near_cross)
                                                   : (q_near_cross - q_far_cross);
   assign close = (CMP_BITS'(gap_main) < CMP_BITS'(max_dist)) &&
                  (CMP_BITS'(gap_cross) < CMP_BITS'(max_dist));

   // Take the queue head whenever the output register is free or being read.
   assign q_pop    = !q_empty && (!valid_ff || rsp_ready);
   assign valid_in = q_pop || (valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         same_ff   <= q_ctrl.check && close;
         status_ff <= q_ctrl.status;
         a_ori_ff  <= q_ctrl.a_ori;
         b_ori_ff  <= q_ctrl.b_ori;
      end
   end

   assign rsp_valid         = valid_ff;
   assign rsp_same_line     = same_ff;
   assign rsp_status        = status_ff;
   assign rsp_a_orientation = a_ori_ff;
   assign rsp_b_orientation = b_ori_ff;

endmodule

[rtl/segment_continuation_test.sv]
// ----------------------------------------------------------------------------
// Segment continuation test
// Decides whether a second line segment continues a first one.
// ----------------------------------------------------------------------------
// The block accepts one segment pair per clock cycle while req_ready is high
// and returns one result per pair, in order. The front classifies the pair
// in the cycle of acceptance and writes a two-entry queue; the back reads the
// queue head into the output register whenever that register is free or being
// read. The sustained rate of one item per cycle is set by that queue and the
// output register; a stalled result side fills the queue and then drops
// req_ready. max_dist may be written at any time the block is idle
// and resets to 8.
module segment_continuation_test #(
   parameter int unsigned COORD_BITS = 12
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [sct_pkg::MAX_DIST_BITS-1:0]  csr_wdata,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [COORD_BITS-1:0]              req_a_start_x,
   input  logic [COORD_BITS-1:0]              req_a_start_y,
   input  logic [COORD_BITS-1:0]              req_a_end_x,
   input  logic [COORD_BITS-1:0]              req_a_end_y,
   input  logic [COORD_BITS-1:0]              req_b_start_x,
   input  logic [COORD_BITS-1:0]              req_b_start_y,
   input  logic [COORD_BITS-1:0]              req_b_end_x,
   input  logic [COORD_BITS-1:0]              req_b_end_y,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic                               rsp_same_line,
   output logic [1:0]                         rsp_status,
   output logic [1:0]                         rsp_a_orientation,
   output logic [1:0]                         rsp_b_orientation
);

`include "segment_continuation_test_macros.svh"

   localparam int unsigned CTRL_BITS = $bits(sct_pkg::ctrl_type);
   localparam int unsigned Q_WIDTH   = CTRL_BITS + 4 * COORD_BITS;
   localparam int unsigned Q_DEPTH   = 2;

   logic [sct_pkg::MAX_DIST_BITS-1:0] max_dist_ff;
   sct_pkg::ctrl_type     f_ctrl;
   logic [COORD_BITS-1:0] f_far_main, f_far_cross, f_near_main, f_near_cross;
   sct_pkg::ctrl_type     q_ctrl;
   logic [COORD_BITS-1:0] q_far_main, q_far_cross, q_near_main, q_near_cross;
   logic [Q_WIDTH-1:0]    q_push_data;
   logic [Q_WIDTH-1:0]    q_head_data;
   logic                  q_push;
   logic                  q_pop;
   logic                  q_full;
   logic                  q_empty;

   // Distance bound register.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_dist_ff <= sct_pkg::MAX_DIST_RESET;
      end else if (csr_valid) begin
         max_dist_ff <= csr_wdata;
      end
   end

   // Front end: classify and pick facing endpoints.
   sct_front #(
      .COORD_BITS (COORD_BITS)
   ) u_front (
      .a_start_x  (req_a_start_x),
      .a_start_y  (req_a_start_y),
      .a_end_x    (req_a_end_x),
      .a_end_y    (req_a_end_y),
      .b_start_x  (req_b_start_x),
      .b_start_y  (req_b_start_y),
      .b_end_x    (req_b_end_x),
      .b_end_y    (req_b_end_y),
      .ctrl       (f_ctrl),
      .far_main   (f_far_main),
      .far_cross  (f_far_cross),
      .near_main  (f_near_main),
      .near_cross (f_near_cross)
   );

   // Queue between front and back.
   assign req_ready   = !q_full;
   assign q_push      = req_valid && req_ready;
   assign q_push_data = {f_ctrl, f_far_main, f_far_cross, f_near_main, f_near_cross};

   sct_queue #(
      .WIDTH (Q_WIDTH),
      .DEPTH (Q_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_push_data),
      .pop       (q_pop),
      .head_data (q_head_data),
      .full      (q_full),
      .empty     (q_empty)
   );

   assign {q_ctrl, q_far_main, q_far_cross, q_near_main, q_near_cross} = q_head_data;

   // Back end: distance test and output register.
   sct_back #(
      .COORD_BITS (COORD_BITS)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .max_dist          (max_dist_ff),
      .q_empty           (q_empty),
      .q_ctrl            (q_ctrl),
      .q_far_main        (q_far_main),
      .q_far_cross       (q_far_cross),
      .q_near_main       (q_near_main),
      .q_near_cross      (q_near_cross),
      .q_pop             (q_pop),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_same_line     (rsp_same_line),
      .rsp_status        (rsp_status),
      .rsp_a_orientation (rsp_a_orientation),
      .rsp_b_orientation (rsp_b_orientation)
   );

   // An accepted item is in the queue at the next edge.
   `SCT_ASSERT_NEXT(a_push_lands, clock, reset, q_push, !q_empty, "accepted item not queued")
   // A pop only happens from a non-empty queue.
   `SCT_ASSERT_IMPLIES(a_pop_nonempty, clock, reset, q_pop, !q_empty, "pop from empty queue")
   // A positive result needs a decided status and two equal straight classes.
   `SCT_ASSERT_IMPLIES(a_same_consistent, clock, reset, rsp_valid && rsp_same_line,
      (rsp_status == sct_pkg::ST_DECIDED) && (rsp_a_orientation == rsp_b_orientation) &&
      (rsp_a_orientation != sct_pkg::ORI_DIAG), "same_line with inconsistent classes")
   // The both-diagonal status goes with two diagonal classes.
   `SCT_ASSERT_IMPLIES(a_diag_status, clock, reset,
      rsp_valid && (rsp_status == sct_pkg::ST_BOTH_DIAG),
      (rsp_a_orientation == sct_pkg::ORI_DIAG) && (rsp_b_orientation == sct_pkg::ORI_DIAG),
      "diagonal status without diagonal classes")

endmodule

[dv/segment_continuation_checker.sv]
// ----------------------------------------------------------------------------
// Segment continuation checker
// Watches the register, request and result channels of the block, predicts
// the verdict of every accepted segment pair and compares each result with
// the oldest prediction, field by field, in order.
// ----------------------------------------------------------------------------
module segment_continuation_checker #(
   parameter int unsigned COORD_BITS = 12
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_valid,
   input  logic                               csr_ready,
   input  logic [sct_pkg::MAX_DIST_BITS-1:0]  csr_wdata,
   input  logic                               req_valid,
   input  logic                               req_ready,
   input  logic [COORD_BITS-1:0]              req_a_start_x,
   input  logic [COORD_BITS-1:0]              req_a_start_y,
   input  logic [COORD_BITS-1:0]              req_a_end_x,
   input  logic [COORD_BITS-1:0]              req_a_end_y,
   input  logic [COORD_BITS-1:0]              req_b_start_x,
   input  logic [COORD_BITS-1:0]              req_b_start_y,
   input  logic [COORD_BITS-1:0]              req_b_end_x,
   input  logic [COORD_BITS-1:0]              req_b_end_y,
   input  logic                               rsp_valid,
   input  logic                               rsp_ready,
   input  logic                               rsp_same_line,
   input  logic [1:0]                         rsp_status,
   input  logic [1:0]                         rsp_a_orientation,
   input  logic [1:0]                         rsp_b_orientation,
   output int                                 verdicts_pending,
   output int                                 mismatch_count,
   output int                                 checked_count,
   output int                                 joined_count,
   output int                                 special_count
);

   typedef logic [COORD_BITS-1:0] coord_type;

   typedef struct packed {
      logic       same_line;
      logic [1:0] status;
      logic [1:0] a_ori;
      logic [1:0] b_ori;
   } verdict_type;

   // Predicted verdicts of accepted pairs, oldest first.
   verdict_type verdict_q [$];

   // Local copy of the distance bound.
   logic [sct_pkg::MAX_DIST_BITS-1:0] dist_limit = sct_pkg::MAX_DIST_RESET;

   function automatic int unsigned span(coord_type p, coord_type q);
      return (p > q) ? int'(p - q) : int'(q - p);
   endfunction

   // Segment coordinates are held as x0, y0, x1, y1.
   function automatic logic [1:0] classify_segment(coord_type s [4]);
      int unsigned dx;
      int unsigned dy;
      dx = span(s[0], s[2]);
      dy = span(s[1], s[3]);
      if (dy == 0) return sct_pkg::ORI_HORZ;
      if (dx == 0) return sct_pkg::ORI_VERT;
      if (5 * dy < 4 * dx) return sct_pkg::ORI_HORZ;
      if (5 * dy > 6 * dx) return sct_pkg::ORI_VERT;
      return sct_pkg::ORI_DIAG;
   endfunction

   // The segment with the smaller minimum along the main axis leads; on a tie
   // the second segment leads. Its far end must face the trailing segment's
   // near end strictly within the bound on both axes.
   function automatic bit segments_continue(coord_type a [4], coord_type b [4], int axis,
                                            int unsigned limit);
      int          cross_ax;
      int unsigned a_min;
      int unsigned b_min;
      int unsigned far_main;
      int unsigned far_cross;
      int unsigned near_main;
      int unsigned near_cross;
      coord_type   lead [4];
      coord_type   trail [4];
      cross_ax = 1 - axis;
      a_min = (a[axis] < a[axis+2]) ? a[axis] : a[axis+2];
      b_min = (b[axis] < b[axis+2]) ? b[axis] : b[axis+2];
      if (a_min < b_min) begin
         lead = a;
         trail = b;
      end else begin
         lead = b;
         trail = a;
      end
      if (lead[axis] < lead[axis+2]) begin
         far_main = lead[axis+2];
         far_cross = lead[cross_ax+2];
      end else begin
         far_main = lead[axis];
         far_cross = lead[cross_ax];
      end
      if (trail[axis] < trail[axis+2]) begin
         near_main = trail[axis];
         near_cross = trail[cross_ax];
      end else begin
         near_main = trail[axis+2];
         near_cross = trail[cross_ax+2];
      end
      return (span(coord_type'(far_cross), coord_type'(near_cross)) < limit) &&
             (span(coord_type'(far_main), coord_type'(near_main)) < limit);
   endfunction

   function automatic verdict_type predict_verdict(coord_type a [4], coord_type b [4],
                                                   int unsigned limit);
      verdict_type v;
      bit          a_zero;
      bit          b_zero;
      v = '0;
      a_zero = (a[0] == a[2]) && (a[1] == a[3]);
      b_zero = (b[0] == b[2]) && (b[1] == b[3]);
      v.a_ori = a_zero ? sct_pkg::ORI_VERT : classify_segment(a);
      v.b_ori = b_zero ? sct_pkg::ORI_VERT : classify_segment(b);
      if (a_zero || b_zero) begin
         v.status = sct_pkg::ST_ZERO_LEN;
      end else if (v.a_ori != v.b_ori) begin
         v.status = sct_pkg::ST_DECIDED;
      end else if (v.a_ori == sct_pkg::ORI_DIAG) begin
         v.status = sct_pkg::ST_BOTH_DIAG;
      end else begin
         v.status = sct_pkg::ST_DECIDED;
         v.same_line = segments_continue(a, b, (v.a_ori == sct_pkg::ORI_HORZ) ? 0 : 1,
                                         limit);
      end
      return v;
   endfunction

   task automatic check_field(input string name, input int unsigned want,
                              input int unsigned got);
      if (want != got) begin
         $error("%s mismatch: expected %0d, got %0d", name, want, got);
         mismatch_count++;
      end
   endtask

   // Results are matched before new pairs are queued, so a result can never
   // be paired with an item accepted in the same cycle.
   always @(posedge clock) begin : watch
      verdict_type got;
      verdict_type want;
      coord_type   a_seg [4];
      coord_type   b_seg [4];
      if (reset) begin
         verdict_q.delete();
         dist_limit = sct_pkg::MAX_DIST_RESET;
      end else begin
         if (csr_valid && csr_ready) dist_limit = csr_wdata;

         if (rsp_valid && rsp_ready) begin
            got = '{rsp_same_line, rsp_status, rsp_a_orientation, rsp_b_orientation};
            if (verdict_q.size() == 0) begin
               $error("result item arrived with no segment pair outstanding");
               mismatch_count++;
            end else begin
               want = verdict_q.pop_front();
               check_field("same_line", want.same_line, got.same_line);
               check_field("status", want.status, got.status);
               check_field("a_orientation", want.a_ori, got.a_ori);
               check_field("b_orientation", want.b_ori, got.b_ori);
               checked_count++;
               if (want.same_line) joined_count++;
               if (want.status != sct_pkg::ST_DECIDED) special_count++;
            end
         end

         if (req_valid && req_ready) begin
            a_seg = '{req_a_start_x, req_a_start_y, req_a_end_x, req_a_end_y};
            b_seg = '{req_b_start_x, req_b_start_y, req_b_end_x, req_b_end_y};
            verdict_q.push_back(predict_verdict(a_seg, b_seg, dist_limit));
         end
      end
      verdicts_pending <= verdict_q.size();
   end

endmodule

[dv/tb_top.sv]
// ----------------------------------------------------------------------------
// Segment continuation test bench
// Drives directed and random segment pairs through the block under several
// distance bounds and stall patterns; the checker beside the block predicts
// and compares every result.
// ----------------------------------------------------------------------------
module tb_top;

   localparam int unsigned COORD_BITS      = 12;
   localparam int unsigned COORD_MAX       = (1 << COORD_BITS) - 1;
   localparam int unsigned WATCHDOG_LIMIT  = 2000;
   localparam int unsigned HOLD_OFF_CYCLES = 60;
   localparam int unsigned TAIL_CYCLES     = 8;
   localparam int unsigned BLOCK_ITEMS     = 90;
   localparam int unsigned NUM_BLOCKS      = 6;

   typedef logic [COORD_BITS-1:0] coord_type;

   typedef struct packed {
      coord_type x0;
      coord_type y0;
      coord_type x1;
      coord_type y1;
   } segment_type;

   typedef struct packed {
      segment_type a;
      segment_type b;
   } seg_pair_type;

   logic                              clock = 1'b0;
   logic                              reset = 1'b1;
   logic                              csr_valid = 1'b0;
   logic                              csr_ready;
   logic [sct_pkg::MAX_DIST_BITS-1:0] csr_wdata = '0;
   logic                              req_valid = 1'b0;
   logic                              req_ready;
   coord_type                         req_a_start_x = '0;
   coord_type                         req_a_start_y = '0;
   coord_type                         req_a_end_x = '0;
   coord_type                         req_a_end_y = '0;
   coord_type                         req_b_start_x = '0;
   coord_type                         req_b_start_y = '0;
   coord_type                         req_b_end_x = '0;
   coord_type                         req_b_end_y = '0;
   logic                              rsp_valid;
   logic                              rsp_ready = 1'b0;
   logic                              rsp_same_line;
   logic [1:0]                        rsp_status;
   logic [1:0]                        rsp_a_orientation;
   logic [1:0]                        rsp_b_orientation;

   int          verdicts_pending;
   int          mismatch_count;
   int          checked_count;
   int          joined_count;
   int          special_count;
   int unsigned send_idle_pct = 0;
   int unsigned recv_idle_pct = 0;
   int unsigned cur_max_dist = sct_pkg::MAX_DIST_RESET;
   int unsigned idle_cycles = 0;
   logic        hold_off_request = 1'b0;

   segment_continuation_test #(
      .COORD_BITS (COORD_BITS)
   ) u_top (
      .clock             (clock),
      .reset             (reset),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_wdata         (csr_wdata),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_a_start_x     (req_a_start_x),
      .req_a_start_y     (req_a_start_y),
      .req_a_end_x       (req_a_end_x),
      .req_a_end_y       (req_a_end_y),
      .req_b_start_x     (req_b_start_x),
      .req_b_start_y     (req_b_start_y),
      .req_b_end_x       (req_b_end_x),
      .req_b_end_y       (req_b_end_y),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_same_line     (rsp_same_line),
      .rsp_status        (rsp_status),
      .rsp_a_orientation (rsp_a_orientation),
      .rsp_b_orientation (rsp_b_orientation)
   );

   segment_continuation_checker #(
      .COORD_BITS (COORD_BITS)
   ) u_checker (
      .clock             (clock),
      .reset             (reset),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_wdata         (csr_wdata),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_a_start_x     (req_a_start_x),
      .req_a_start_y     (req_a_start_y),
      .req_a_end_x       (req_a_end_x),
      .req_a_end_y       (req_a_end_y),
      .req_b_start_x     (req_b_start_x),
      .req_b_start_y     (req_b_start_y),
      .req_b_end_x       (req_b_end_x),
      .req_b_end_y       (req_b_end_y),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_same_line     (rsp_same_line),
      .rsp_status        (rsp_status),
      .rsp_a_orientation (rsp_a_orientation),
      .rsp_b_orientation (rsp_b_orientation),
      .verdicts_pending  (verdicts_pending),
      .mismatch_count    (mismatch_count),
      .checked_count     (checked_count),
      .joined_count      (joined_count),
      .special_count     (special_count)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Result side: random stalls, or one long hold-off when requested.
   initial begin
      forever begin
         @(posedge clock);
         if (hold_off_request) begin
            hold_off_request = 1'b0;
            rsp_ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
         end else begin
            rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
         end
      end
   end

   // Watchdog on cycles in which no item moves on any channel.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   function automatic coord_type clamp_coord(int v);
      if (v < 0) return '0;
      if (v > int'(COORD_MAX)) return coord_type'(COORD_MAX);
      return coord_type'(v);
   endfunction

   // Builds a segment; flip swaps its start and end points.
   function automatic segment_type make_segment(int x0, int y0, int x1, int y1, bit flip);
      segment_type s;
      s = '{clamp_coord(x0), clamp_coord(y0), clamp_coord(x1), clamp_coord(y1)};
      if (flip) s = '{s.x1, s.y1, s.x0, s.y0};
      return s;
   endfunction

   function automatic seg_pair_type pair_of(int ax0, int ay0, int ax1, int ay1,
                                            int bx0, int by0, int bx1, int by1);
      return '{make_segment(ax0, ay0, ax1, ay1, 1'b0),
               make_segment(bx0, by0, bx1, by1, 1'b0)};
   endfunction

   // A segment whose slope sits near one of the class thresholds or is random.
   function automatic segment_type slope_segment();
      int dx;
      int dy;
      int x0;
      int y0;
      dx = $urandom_range(1, 800);
      case ($urandom_range(0, 2))
         0: dy = (4 * dx) / 5 + int'($urandom_range(0, 2)) - 1;
         1: dy = (6 * dx) / 5 + int'($urandom_range(0, 2)) - 1;
         default: dy = $urandom_range(0, 800);
      endcase
      if (dy < 0) dy = 0;
      x0 = $urandom_range(0, 3200);
      y0 = $urandom_range(0, 3200);
      if ($urandom_range(0, 1)) dy = -dy;
      if (dy < 0) y0 = y0 + 800;
      return make_segment(x0, y0, x0 + dx, y0 + dy, $urandom_range(0, 1));
   endfunction

   // Mostly well-formed continuations around the current bound, with ties,
   // threshold slopes, zero-length segments and raw noise mixed in.
   function automatic seg_pair_type random_pair(int unsigned bound);
      seg_pair_type p;
      int           kind;
      int           spread;
      int           m0;
      int           c0;
      int           len;
      int           tilt;
      int           m2;
      int           c2;
      int           len2;
      int           tilt2;
      bit           horiz;
      kind = $urandom_range(0, 99);
      if (kind < 58) begin
         spread = (bound > 40) ? 40 : int'(bound) + 2;
         horiz = $urandom_range(0, 1);
         m0 = $urandom_range(0, 3000);
         c0 = $urandom_range(0, 4095);
         len = $urandom_range(1, 500);
         tilt = int'($urandom_range(0, len / 2)) - len / 4;
         m2 = m0 + len + int'($urandom_range(0, 2 * spread)) - spread;
         c2 = c0 + tilt + int'($urandom_range(0, 2 * spread)) - spread;
         // Same minimum along the main axis exercises the tie rule.
         if (kind >= 50) m2 = m0;
         len2 = $urandom_range(1, 500);
         tilt2 = int'($urandom_range(0, len2 / 2)) - len2 / 4;
         if (horiz) begin
            p.a = make_segment(m0, c0, m0 + len, c0 + tilt, $urandom_range(0, 1));
            p.b = make_segment(m2, c2, m2 + len2, c2 + tilt2, $urandom_range(0, 1));
         end else begin
            p.a = make_segment(c0, m0, c0 + tilt, m0 + len, $urandom_range(0, 1));
            p.b = make_segment(c2, m2, c2 + tilt2, m2 + len2, $urandom_range(0, 1));
         end
         if ($urandom_range(0, 1)) p = '{p.b, p.a};
      end else if (kind < 73) begin
         p = '{slope_segment(), slope_segment()};
      end else if (kind < 80) begin
         p = '{slope_segment(), slope_segment()};
         case ($urandom_range(0, 2))
            0: p.a = '{p.a.x0, p.a.y0, p.a.x0, p.a.y0};
            1: p.b = '{p.b.x0, p.b.y0, p.b.x0, p.b.y0};
            default: begin
               p.a = '{p.a.x0, p.a.y0, p.a.x0, p.a.y0};
               p.b = '{p.b.x0, p.b.y0, p.b.x0, p.b.y0};
            end
         endcase
      end else begin
         p = {$urandom(), $urandom(), $urandom()};
      end
      return p;
   endfunction

   // Offers one pair after a random gap and holds it until accepted.
   task automatic send_pair(input seg_pair_type p);
      int gap;
      gap = 0;
      while ($urandom_range(0, 99) < send_idle_pct) gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_a_start_x <= p.a.x0;
      req_a_start_y <= p.a.y0;
      req_a_end_x <= p.a.x1;
      req_a_end_y <= p.a.y1;
      req_b_start_x <= p.b.x0;
      req_b_start_y <= p.b.y0;
      req_b_end_x <= p.b.x1;
      req_b_end_y <= p.b.y1;
      do @(posedge clock); while (!req_ready);
   endtask

   // Writes the distance bound once every outstanding result has arrived.
   task automatic write_max_dist(input int unsigned value);
      req_valid <= 1'b0;
      @(posedge clock);
      while (verdicts_pending != 0) @(posedge clock);
      csr_valid <= 1'b1;
      csr_wdata <= value[sct_pkg::MAX_DIST_BITS-1:0];
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      cur_max_dist = value;
   endtask

   initial begin
      seg_pair_type directed [$];
      int unsigned  dist_plan [NUM_BLOCKS];
      int           blk;

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed pairs under the reset bound of 8.
      directed = '{
         pair_of(10, 100, 50, 100, 55, 102, 90, 101),       // horizontal, joined
         pair_of(10, 100, 50, 100, 58, 100, 90, 101),       // gap equals the bound
         pair_of(50, 100, 10, 100, 90, 101, 55, 102),       // endpoints reversed
         pair_of(55, 102, 90, 101, 10, 100, 50, 100),       // second segment leads
         pair_of(10, 100, 50, 100, 10, 100, 60, 100),       // tie on leftmost x
         pair_of(200, 10, 200, 60, 203, 66, 204, 120),      // vertical, joined
         pair_of(200, 10, 200, 60, 208, 66, 209, 120),      // offset equals the bound
         pair_of(300, 10, 300, 50, 302, 10, 301, 80),       // tie on topmost y
         pair_of(0, 0, 100, 100, 200, 200, 300, 300),       // both diagonal
         pair_of(0, 0, 100, 0, 0, 0, 0, 100),               // classes differ
         pair_of(5, 5, 5, 5, 10, 10, 40, 10),               // first zero length
         pair_of(7, 7, 7, 90, 9, 9, 9, 9),                  // second zero length
         pair_of(4095, 4095, 4095, 4095, 0, 0, 0, 0),       // both zero length
         pair_of(0, 0, 5, 4, 0, 0, 5, 3),                   // diagonal at the 4/5 slope threshold
         pair_of(0, 0, 5, 6, 0, 0, 5, 7),                   // diagonal at the 6/5 slope threshold
         pair_of(0, 0, 4095, 0, 4095, 4095, 0, 4095),       // full-width horizontals
         pair_of(4095, 0, 0, 4095, 0, 4095, 4095, 0),       // full-range diagonals
         pair_of(0, 0, 10, 0, 10, 0, 20, 0),                // touching ends
         pair_of(0, 0, 1, 4095, 0, 4095, 4095, 4094),       // steepest and flattest
         pair_of(4095, 0, 4095, 4090, 4095, 4095, 4094, 4093), // joined at the top
         pair_of(4095, 4095, 0, 4095, 0, 4095, 4095, 4095)  // identical horizontals
      };
      foreach (directed[i]) send_pair(directed[i]);

      // Random blocks: each under its own bound; pairs of blocks share a stall pattern.
      dist_plan = '{0, COORD_MAX, 1, $urandom_range(2, 64), 16, $urandom_range(0, 4095)};
      for (blk = 0; blk < NUM_BLOCKS; blk++) begin
         write_max_dist(dist_plan[blk]);
         if (blk < 2) begin
            send_idle_pct = 11;
            recv_idle_pct = 69;
         end else if (blk < 4) begin
            send_idle_pct = 69;
            recv_idle_pct = 11;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         if (blk == 2 || blk == 4) hold_off_request = 1'b1;
         repeat (BLOCK_ITEMS) send_pair(random_pair(cur_max_dist));
      end

      // Drain the remaining results, then wait out the tail before the summary.
      req_valid <= 1'b0;
      @(posedge clock);
      while (verdicts_pending != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Compared %0d segment pairs under %0d distance bounds: %0d joined, %0d flagged.",
               checked_count, NUM_BLOCKS + 1, joined_count, special_count);
      $display("Stalls ran sender-light, receiver-light and none, with long result hold-offs.");
      if (mismatch_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
